// ===== rtl/fmq_pkg.sv =====
// Shared types and constants for the filtered message queue.
package fmq_pkg;

    localparam int          QUEUE_DEPTH_DEF = 16;
    localparam logic [31:0] QUIT_CODE_RST   = 32'd18;
    localparam logic [31:0] CODE_ALL_ONES   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_POST = 2'd0,
        REQ_GET  = 2'd1,
        REQ_PEEK = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_CLOSED   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE    = 1'b0,
        S_SQUEEZE = 1'b1
    } state_t;

    typedef struct packed {
        logic [15:0] window;
        logic [31:0] code;
        logic [63:0] param;
        logic [63:0] long_p;
    } entry_t;

    typedef struct packed {
        logic        eval;
        logic        is_get;
        logic        is_peek;
        logic        rem;
        logic        post;
        logic        squeeze;
        logic [15:0] filt_window;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] quit_code;
        entry_t      entry;
    } ctrl_t;

    typedef struct packed {
        logic   found;
        logic   quit_seen;
        logic   hole;
        logic   prev_valid;
        entry_t sel;
    } fwd_t;

    typedef struct packed {
        logic   valid;
        logic   kill;
        entry_t data;
    } bwd_t;

endpackage

// ===== rtl/fmq_intf.sv =====
// Handshake channels for requests, responses and the quit code register.
interface fmq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] window_id;
    logic [31:0] msg_code;
    logic [63:0] param_word;
    logic [63:0] long_param;
    logic [31:0] filter_min;
    logic [31:0] filter_max;
    logic        remove_flag;

    modport source (
        output valid, req_type, window_id, msg_code, param_word, long_param,
               filter_min, filter_max, remove_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, window_id, msg_code, param_word, long_param,
               filter_min, filter_max, remove_flag,
        output ready
    );
endinterface

interface fmq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_window;
    logic [31:0] out_code;
    logic [63:0] out_param_word;
    logic [63:0] out_long_param;

    modport source (
        output valid, status, out_window, out_code, out_param_word, out_long_param,
        input  ready
    );
    modport sink (
        input  valid, status, out_window, out_code, out_param_word, out_long_param,
        output ready
    );
endinterface

interface fmq_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] quit_code;

    modport source (
        output valid, quit_code,
        input  ready
    );
    modport sink (
        input  valid, quit_code,
        output ready
    );
endinterface

// ===== rtl/filtered_message_queue_top.sv =====
// Filtered message queue: a row of slot cells, request control and response register.
// After a request is taken, the queue compacts its removed slots and then loads the response
//   register once that is free; no new request is taken until the response is loaded.
// A get can remove up to QUEUE_DEPTH entries; the compaction shifts one hole a cycle.
// Reset: queue empty and open, quit_code 18; slot contents are not cleared.
module filtered_message_queue_top #(
    parameter int QUEUE_DEPTH = fmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fmq_req_if.sink   req,
    fmq_rsp_if.source rsp,
    fmq_cfg_if.sink   cfg
);

    fmq_pkg::state_t  state_reg;
    fmq_pkg::state_t  state_next;
    logic             closed_reg;
    logic             closed_next;
    logic [31:0]      quit_code_reg;
    logic [31:0]      quit_code_next;
    fmq_pkg::status_t res_status_reg;
    fmq_pkg::status_t res_status_next;
    fmq_pkg::entry_t  res_entry_reg;
    fmq_pkg::entry_t  res_entry_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    fmq_pkg::status_t rsp_status_reg;
    fmq_pkg::status_t rsp_status_next;
    fmq_pkg::entry_t  rsp_entry_reg;
    fmq_pkg::entry_t  rsp_entry_next;

    fmq_pkg::ctrl_t   ctrl;
    fmq_pkg::fwd_t    fwd [QUEUE_DEPTH+1];
    fmq_pkg::bwd_t    bwd [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] valid_vec;

    logic accept;
    logic full;
    logic any_kill;
    logic load_rsp;
    logic is_post;

    assign req.ready = (state_reg == fmq_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign full      = fwd[QUEUE_DEPTH].prev_valid;
    assign any_kill  = fwd[QUEUE_DEPTH].hole;
    assign is_post   = (req.req_type == fmq_pkg::REQ_POST);

    assign fwd[0] = '{found: 1'b0, quit_seen: 1'b0, hole: 1'b0, prev_valid: 1'b1, sel: '0};
    assign bwd[QUEUE_DEPTH] = '0;

    always_comb
    begin
        ctrl.eval        = accept;
        ctrl.is_get      = (req.req_type == fmq_pkg::REQ_GET);
        ctrl.is_peek     = (req.req_type == fmq_pkg::REQ_PEEK);
        ctrl.rem         = req.remove_flag;
        ctrl.post        = is_post && !closed_reg && !full;
        ctrl.squeeze     = (state_reg == fmq_pkg::S_SQUEEZE);
        ctrl.filt_window = req.window_id;
        ctrl.lo          = req.filter_min;
        ctrl.hi          = (req.filter_max == 32'd0) ? fmq_pkg::CODE_ALL_ONES : req.filter_max;
        ctrl.quit_code   = quit_code_reg;
        ctrl.entry       = '{window: req.window_id, code: req.msg_code,
                             param: req.param_word, long_p: req.long_param};
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            fmq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .fwd_in  (fwd[gi]),
                .fwd_out (fwd[gi+1]),
                .bwd_in  (bwd[gi+1]),
                .bwd_out (bwd[gi])
            );
            assign valid_vec[gi] = fwd[gi+1].prev_valid;
        end
    endgenerate

    always_comb
    begin
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        closed_next     = closed_reg;
        quit_code_next  = cfg.valid ? cfg.quit_code : quit_code_reg;
        if (accept)
        begin
            res_entry_next = fwd[QUEUE_DEPTH].sel;
            case (req.req_type)
                fmq_pkg::REQ_POST:
                begin
                    if (closed_reg)
                        res_status_next = fmq_pkg::ST_CLOSED;
                    else if (full)
                        res_status_next = fmq_pkg::ST_FULL;
                    else
                        res_status_next = fmq_pkg::ST_OK;
                end
                fmq_pkg::REQ_GET:
                begin
                    closed_next = closed_reg || fwd[QUEUE_DEPTH].quit_seen;
                    if (fwd[QUEUE_DEPTH].found)
                        res_status_next = fmq_pkg::ST_OK;
                    else if (closed_next)
                        res_status_next = fmq_pkg::ST_CLOSED;
                    else
                        res_status_next = fmq_pkg::ST_NO_MATCH;
                end
                fmq_pkg::REQ_PEEK:
                begin
                    res_status_next = fwd[QUEUE_DEPTH].found ? fmq_pkg::ST_OK
                                                             : fmq_pkg::ST_NO_MATCH;
                end
                default:
                begin
                    res_status_next = fmq_pkg::ST_NO_MATCH;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_rsp   = 1'b0;
        case (state_reg)
            fmq_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = fmq_pkg::S_SQUEEZE;
            end
            fmq_pkg::S_SQUEEZE:
            begin
                if (!any_kill && (!rsp_valid_reg || rsp.ready))
                begin
                    load_rsp   = 1'b1;
                    state_next = fmq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fmq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_entry_next  = rsp_entry_reg;
        if (load_rsp)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = res_status_reg;
            rsp_entry_next  = res_entry_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmq_pkg::S_IDLE;
            closed_reg    <= 1'b0;
            quit_code_reg <= fmq_pkg::QUIT_CODE_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            closed_reg    <= closed_next;
            quit_code_reg <= quit_code_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        rsp_status_reg <= rsp_status_next;
        rsp_entry_reg  <= rsp_entry_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.out_window     = rsp_entry_reg.window;
    assign rsp.out_code       = rsp_entry_reg.code;
    assign rsp.out_param_word = rsp_entry_reg.param;
    assign rsp.out_long_param = rsp_entry_reg.long_p;

`ifndef SYNTHESIS
    a_idle_compacted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmq_pkg::S_IDLE) |-> !any_kill)
        else $error("removal pending while taking requests");

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(closed_reg))
        else $error("closed queue reopened");

    a_slots_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1}) & valid_vec) == '0)
        else $error("occupied slots not packed from slot zero");

    a_full_post_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_post && full) |=> (valid_vec == $past(valid_vec)))
        else $error("post into full queue changed occupancy");
`endif

endmodule

// ===== rtl/fmq_cell.sv =====
// One queue slot: holds an entry, matches it, and shifts down over removed slots.
module fmq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  fmq_pkg::ctrl_t  ctrl,
    input  fmq_pkg::fwd_t   fwd_in,
    output fmq_pkg::fwd_t   fwd_out,
    input  fmq_pkg::bwd_t   bwd_in,
    output fmq_pkg::bwd_t   bwd_out
);

    logic            valid_reg;
    logic            valid_next;
    logic            kill_reg;
    logic            kill_next;
    fmq_pkg::entry_t data_reg;
    fmq_pkg::entry_t data_next;

    logic win_ok;
    logic code_ok;
    logic is_quit;
    logic cand;
    logic hit;
    logic quit_kill;
    logic hole_seen;

    always_comb
    begin
        win_ok    = (ctrl.filt_window == 16'd0) || (data_reg.window == ctrl.filt_window);
        code_ok   = (data_reg.code >= ctrl.lo) && (data_reg.code <= ctrl.hi);
        is_quit   = (data_reg.code == ctrl.quit_code);
        cand      = valid_reg && win_ok && code_ok && !(ctrl.is_get && is_quit);
        hit       = ctrl.eval && (ctrl.is_get || ctrl.is_peek) && cand && !fwd_in.found;
        quit_kill = ctrl.eval && ctrl.is_get && valid_reg && is_quit && !fwd_in.found;
        hole_seen = fwd_in.hole || kill_reg;

        fwd_out.found      = fwd_in.found || hit;
        fwd_out.quit_seen  = fwd_in.quit_seen || quit_kill;
        fwd_out.hole       = hole_seen;
        fwd_out.prev_valid = valid_reg;
        fwd_out.sel        = fwd_in.sel | (hit ? data_reg : '0);

        bwd_out.valid = valid_reg;
        bwd_out.kill  = kill_reg;
        bwd_out.data  = data_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        kill_next  = kill_reg;
        data_next  = data_reg;
        if (ctrl.eval)
        begin
            kill_next = quit_kill || (hit && (ctrl.is_get || ctrl.rem));
            if (ctrl.post && !valid_reg && fwd_in.prev_valid)
            begin
                valid_next = 1'b1;
                data_next  = ctrl.entry;
            end
        end
        else if (ctrl.squeeze && hole_seen)
        begin
            valid_next = bwd_in.valid;
            kill_next  = bwd_in.kill;
            data_next  = bwd_in.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the filtered message queue: directed and random requests checked by a scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = fmq_pkg::QUEUE_DEPTH_DEF;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          QUIET_LIMIT = 5000;
    localparam logic [63:0] WORD_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] win;
        logic [31:0] code;
        logic [63:0] p0;
        logic [63:0] p1;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        rem;
    } request_t;

    typedef struct {
        fmq_pkg::status_t status;
        fmq_pkg::entry_t  data;
    } reply_t;

    class fmq_tracker;
        fmq_pkg::entry_t held[$];
        bit              closed;
        logic [31:0]     quit_code;
        reply_t          replies_due[$];
        int              faults;

        function new();
            closed    = 1'b0;
            quit_code = fmq_pkg::QUIT_CODE_RST;
            faults    = 0;
        endfunction

        function bit hit(fmq_pkg::entry_t e, logic [15:0] win, logic [31:0] lo,
                         logic [31:0] hi);
            return (win == 16'd0 || e.window == win) && e.code >= lo && e.code <= hi;
        endfunction

        function void note_request(request_t r);
            reply_t      due;
            logic [31:0] hi;
            int          i;
            bit          found;
            due.status = fmq_pkg::ST_NO_MATCH;
            due.data   = '0;
            hi         = (r.hi == 32'd0) ? fmq_pkg::CODE_ALL_ONES : r.hi;
            found      = 1'b0;
            case (r.kind)
                fmq_pkg::REQ_POST:
                begin
                    if (closed)
                        due.status = fmq_pkg::ST_CLOSED;
                    else if (held.size() >= DEPTH)
                        due.status = fmq_pkg::ST_FULL;
                    else
                    begin
                        held.push_back('{window: r.win, code: r.code, param: r.p0,
                                         long_p: r.p1});
                        due.status = fmq_pkg::ST_OK;
                    end
                end
                fmq_pkg::REQ_GET:
                begin
                    i = 0;
                    while (i < held.size() && !found)
                    begin
                        if (held[i].code == quit_code)
                        begin
                            closed = 1'b1;
                            held.delete(i);
                        end
                        else if (hit(held[i], r.win, r.lo, hi))
                        begin
                            due.status = fmq_pkg::ST_OK;
                            due.data   = held[i];
                            held.delete(i);
                            found = 1'b1;
                        end
                        else
                            i++;
                    end
                    if (!found)
                        due.status = closed ? fmq_pkg::ST_CLOSED : fmq_pkg::ST_NO_MATCH;
                end
                fmq_pkg::REQ_PEEK:
                begin
                    for (i = 0; i < held.size() && !found; i++)
                    begin
                        if (hit(held[i], r.win, r.lo, hi))
                        begin
                            due.status = fmq_pkg::ST_OK;
                            due.data   = held[i];
                            if (r.rem)
                                held.delete(i);
                            found = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            replies_due.push_back(due);
        endfunction

        function void check_response(logic [1:0] st, logic [15:0] win, logic [31:0] code,
                                     logic [63:0] p0, logic [63:0] p1);
            reply_t due;
            if (replies_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected response: status %0d window %h code %h", st, win,
                             code);
                return;
            end
            due = replies_due.pop_front();
            if (st !== due.status || win !== due.data.window || code !== due.data.code ||
                p0 !== due.data.param || p1 !== due.data.long_p)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("mismatch: expected status %0d window %h code %h p %h %h",
                             due.status, due.data.window, due.data.code, due.data.param,
                             due.data.long_p);
                    $display("          actual   status %0d window %h code %h p %h %h",
                             st, win, code, p0, p1);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    int         idle_pct;
    int         stall_pct;
    int         quiet_cycles;
    fmq_tracker tracker;

    fmq_req_if req_if ();
    fmq_rsp_if rsp_if ();
    fmq_cfg_if cfg_if ();

    filtered_message_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            tracker.check_response(rsp_if.status, rsp_if.out_window, rsp_if.out_code,
                                   rsp_if.out_param_word, rsp_if.out_long_param);
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic request_t mk(logic [1:0] kind, logic [15:0] win, logic [31:0] code,
                                    logic [63:0] p0, logic [63:0] p1, logic [31:0] lo,
                                    logic [31:0] hi, logic rem);
        request_t r;
        r.kind = kind;
        r.win  = win;
        r.code = code;
        r.p0   = p0;
        r.p1   = p1;
        r.lo   = lo;
        r.hi   = hi;
        r.rem  = rem;
        return r;
    endfunction

    function automatic logic [15:0] pick_window();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 16'($urandom_range(1, 4));
        else if (roll < 85)
            return 16'h0000;
        else if (roll < 90)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] pick_code(bit quit_ok);
        logic [31:0] c;
        int          roll;
        if (quit_ok && $urandom_range(99) < 8)
            return tracker.quit_code;
        do
        begin
            roll = $urandom_range(99);
            if (roll < 75)
                c = $urandom_range(1, 40);
            else if (roll < 80)
                c = 32'd0;
            else if (roll < 85)
                c = fmq_pkg::CODE_ALL_ONES;
            else
                c = $urandom;
        end
        while (c == tracker.quit_code);
        return c;
    endfunction

    function automatic request_t make_request(bit post_heavy, bit quit_ok);
        request_t r;
        int       roll;
        roll = $urandom_range(99);
        if (roll < 2)
            r.kind = REQ_UNUSED;
        else if (roll < (post_heavy ? 65 : 35))
            r.kind = fmq_pkg::REQ_POST;
        else if ($urandom_range(99) < 60)
            r.kind = fmq_pkg::REQ_GET;
        else
            r.kind = fmq_pkg::REQ_PEEK;
        r.win  = (r.kind != fmq_pkg::REQ_POST && $urandom_range(99) < 35) ? 16'd0
                                                                          : pick_window();
        r.code = pick_code(quit_ok);
        r.p0   = {$urandom, $urandom};
        r.p1   = {$urandom, $urandom};
        roll   = $urandom_range(99);
        r.lo   = (roll < 70) ? 32'($urandom_range(0, 30)) : (roll < 80) ? 32'd0 : $urandom;
        roll   = $urandom_range(99);
        if (roll < 35)
            r.hi = 32'd0;
        else if (roll < 75)
            r.hi = r.lo + 32'($urandom_range(0, 25));
        else if (roll < 85)
            r.hi = fmq_pkg::CODE_ALL_ONES;
        else
            r.hi = $urandom;
        r.rem = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic send_request(request_t r);
        if ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.kind;
        req_if.window_id   <= r.win;
        req_if.msg_code    <= r.code;
        req_if.param_word  <= r.p0;
        req_if.long_param  <= r.p1;
        req_if.filter_min  <= r.lo;
        req_if.filter_max  <= r.hi;
        req_if.remove_flag <= r.rem;
        do
            @(posedge clk);
        while (!req_if.ready);
        tracker.note_request(r);
    endtask

    task automatic pause_for_replies();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.replies_due.size() != 0);
    endtask

    task automatic write_quit_code(logic [31:0] value);
        cfg_if.valid     <= 1'b1;
        cfg_if.quit_code <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tracker.quit_code = value;
    endtask

    task automatic drain_queue();
        while (tracker.held.size() > 0)
            send_request(mk(fmq_pkg::REQ_GET, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0,
                            1'b0));
    endtask

    task automatic reconfigure(logic [31:0] value);
        drain_queue();
        pause_for_replies();
        write_quit_code(value);
    endtask

    task automatic run_phase(int items, int idle, int stall, bit quit_tail);
        int n;
        idle_pct  = idle;
        stall_pct = stall;
        for (n = 0; n < items; n++)
            send_request(make_request((n / 20) % 2 == 0, quit_tail && n >= items - 35));
    endtask

    task automatic open_queue_cases();
        int k;
        idle_pct  = 28;
        stall_pct = 28;
        send_request(mk(fmq_pkg::REQ_GET, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_PEEK, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1));
        send_request(mk(REQ_UNUSED, 16'hFFFF, fmq_pkg::CODE_ALL_ONES, WORD_ONES, WORD_ONES,
                        fmq_pkg::CODE_ALL_ONES, fmq_pkg::CODE_ALL_ONES, 1'b1));
        send_request(mk(fmq_pkg::REQ_POST, 16'hFFFF, fmq_pkg::CODE_ALL_ONES, WORD_ONES,
                        WORD_ONES, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_POST, 16'h0000, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0,
                        1'b0));
        send_request(mk(fmq_pkg::REQ_POST, 16'd1, 32'd5, {$urandom, $urandom},
                        {$urandom, $urandom}, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_PEEK, 16'hFFFF, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0,
                        1'b0));
        send_request(mk(fmq_pkg::REQ_PEEK, 16'd1, 32'd0, 64'd0, 64'd0, 32'd5, 32'd5, 1'b1));
        send_request(mk(fmq_pkg::REQ_GET, 16'd2, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_GET, 16'd0, 32'd0, 64'd0, 64'd0, 32'd1, 32'hFFFF_FFFE,
                        1'b0));
        send_request(mk(fmq_pkg::REQ_GET, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
        for (k = 0; k <= DEPTH - 1; k++)
            send_request(mk(fmq_pkg::REQ_POST, 16'(k + 1), 32'(k + 20), {$urandom, $urandom},
                            {$urandom, $urandom}, 32'd0, 32'd0, 1'b0));
    endtask

    task automatic closed_queue_cases();
        idle_pct  = 28;
        stall_pct = 28;
        if (!tracker.closed)
            drain_queue();
        if (!tracker.closed)
        begin
            send_request(mk(fmq_pkg::REQ_POST, 16'd3, 32'd7, {$urandom, $urandom},
                            {$urandom, $urandom}, 32'd0, 32'd0, 1'b0));
            send_request(mk(fmq_pkg::REQ_POST, 16'd3, tracker.quit_code, {$urandom, $urandom},
                            {$urandom, $urandom}, 32'd0, 32'd0, 1'b0));
            send_request(mk(fmq_pkg::REQ_POST, 16'd3, 32'd9, {$urandom, $urandom},
                            {$urandom, $urandom}, 32'd0, 32'd0, 1'b0));
            send_request(mk(fmq_pkg::REQ_GET, 16'd3, 32'd0, 64'd0, 64'd0, 32'd9,
                            tracker.quit_code + 32'd2, 1'b0));
        end
        send_request(mk(fmq_pkg::REQ_POST, 16'd4, 32'd11, {$urandom, $urandom},
                        {$urandom, $urandom}, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_PEEK, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_PEEK, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1));
        drain_queue();
        send_request(mk(fmq_pkg::REQ_PEEK, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
        send_request(mk(fmq_pkg::REQ_GET, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        quiet_cycles       = 0;
        tracker            = new();
        req_if.valid       = 1'b0;
        req_if.req_type    = fmq_pkg::REQ_POST;
        req_if.window_id   = '0;
        req_if.msg_code    = '0;
        req_if.param_word  = '0;
        req_if.long_param  = '0;
        req_if.filter_min  = '0;
        req_if.filter_max  = '0;
        req_if.remove_flag = 1'b0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.quit_code   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        open_queue_cases();

        reconfigure(fmq_pkg::CODE_ALL_ONES);
        run_phase(100, 0, 0, 1'b0);

        reconfigure(32'd0);
        run_phase(100, 69, 0, 1'b0);

        reconfigure($urandom);
        run_phase(50, 0, 69, 1'b0);
        pause_for_replies();
        run_phase(50, 0, 69, 1'b0);

        reconfigure(fmq_pkg::QUIT_CODE_RST);
        run_phase(100, 28, 28, 1'b1);

        closed_queue_cases();
        run_phase(40, 28, 28, 1'b0);

        pause_for_replies();
        repeat (40) @(posedge clk);
        if (tracker.faults == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
